@@ rtl/cnc_pkg.sv @@
// ----------------------------------------------------------------------------
// cnc_pkg: shared types and constants
// Payload structs, command and status codes, controller/datapath buses and
// the offset-network switch count helper.
// ----------------------------------------------------------------------------
package cnc_pkg;

   localparam int CFG_W         = 11;
   localparam int TGT_W         = 10;
   localparam int SWI_W         = 16;
   localparam int SW_W          = 17;   // switch counts
   localparam int EXP_W         = 5;    // power-of-two exponents
   localparam int DEF_MAX_ITEMS = 1024;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_MARK  = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [TGT_W-1:0] target_index;
   } req_type;

   typedef struct packed {
      logic             control_bit;
      logic [SWI_W-1:0] switch_index;
      logic             last;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic simple;       // clear, mark or unknown request
      logic build_init;
      logic build_step;
      logic tot_step;
      logic fetch_init;
      logic resp_empty;
      logic rd_b;
      logic eval;
      logic fin2;
   } dp_cmd_type;

   typedef struct packed {
      logic ready;
      logic build_end;
      logic hit;
      logic tot_last;
      logic exhausted;
      logic need_c;
      logic level_done;
   } dp_sts_type;

   // switches in an offset network over 2**e positions: e * 2**(e-1)
   function automatic logic [SW_W-1:0] oc_pow(input logic [EXP_W-1:0] e);
      logic [SW_W-1:0] v;
      v = SW_W'(e);
      if (e == '0) return '0;
      return v << (e - EXP_W'(1));
   endfunction

endpackage

@@ rtl/cnc_ram.sv @@
// ----------------------------------------------------------------------------
// cnc_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/cnc_dp.sv @@
// ----------------------------------------------------------------------------
// cnc_dp: compaction control datapath
// Mark list, prefix-count memory, build sweep, switch total and the
// per-level descent arithmetic; holds the response register.
// ----------------------------------------------------------------------------
module cnc_dp #(
   parameter int MAX_ITEMS = cnc_pkg::DEF_MAX_ITEMS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cnc_pkg::dp_cmd_type        cmd,
   output cnc_pkg::dp_sts_type        sts,
   input  cnc_pkg::req_type           req_data,
   input  logic                       cfg_we,
   input  logic [cnc_pkg::CFG_W-1:0]  cfg_data,
   output logic                       rsp_valid,
   output cnc_pkg::rsp_type           rsp_data
);
   import cnc_pkg::*;

   localparam int CW      = $clog2(MAX_ITEMS + 1);
   localparam int LAW     = $clog2(MAX_ITEMS);
   localparam int RST_CNT = (MAX_ITEMS < 1024) ? MAX_ITEMS : 1024;

   logic [CW-1:0]    count_ff, count_in, nmarks_ff, nmarks_in;
   logic [TGT_W-1:0] last_ff, last_in;
   logic             any_ff, any_in, ready_ff, ready_in;
   logic [SW_W-1:0]  emit_ff, emit_in, total_ff, total_in;
   logic [CW-1:0]    i_ff, i_in, acc_ff, acc_in, j_ff, j_in;
   logic [EXP_W-1:0] tb_ff, tb_in, e_ff, e_in;
   logic [CW-1:0]    base_ff, base_in, c_ff, c_in, off_ff, off_in;
   logic [SW_W-1:0]  k_ff, k_in, cc_ff, cc_in;
   logic             ofs_ff, ofs_in;
   logic [CW-1:0]    pa_ff, pa_in, pb_ff, pb_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             list_we;
   logic [TGT_W-1:0] list_rdata;
   logic             pfx_we;
   logic [CW-1:0]    pfx_waddr, pfx_wdata, pfx_raddr, pfx_rdata;

   logic [EXP_W-1:0] c_e, e_m1;
   logic [CW-1:0]    p_v, r_v, half_v, m_v, ml_v, off_c, bnd, acc_n, mask_v;
   logic [SW_W-1:0]  oc_c, n1, k2, k3, oc_h, oc_2h, i_v, tot_add;
   logic [CW:0]      sum1;
   logic             c_left, c_off, cbit, o_left, o_right, wrap, obit, ebit;
   logic             m0, m1, fbit, hit, need_c, level_done, tgt_bad, tot_bit;
   logic             do_resp, resp_bit;

   cnc_ram #(.WIDTH(TGT_W), .DEPTH(MAX_ITEMS)) u_list (
      .clock (clock),
      .we    (list_we),
      .waddr (nmarks_ff[LAW-1:0]),
      .wdata (req_data.target_index),
      .raddr (j_ff[LAW-1:0]),
      .rdata (list_rdata)
   );

   cnc_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS + 1)) u_pfx (
      .clock (clock),
      .we    (pfx_we),
      .waddr (pfx_waddr),
      .wdata (pfx_wdata),
      .raddr (pfx_raddr),
      .rdata (pfx_rdata)
   );

   // top set bit of the current compact span
   always_comb begin
      c_e = '0;
      for (int b = 0; b < CW; b++) begin
         if (c_ff[b]) c_e = EXP_W'(b);
      end
   end

   assign p_v    = CW'(1) << c_e;
   assign r_v    = c_ff ^ p_v;
   assign e_m1   = e_ff - EXP_W'(1);
   assign half_v = CW'(1) << e_m1;
   assign m_v    = half_v - CW'(1);
   assign ml_v   = pfx_rdata - pa_ff;

   // compact level
   assign oc_c   = oc_pow(c_e);
   assign n1     = cc_ff - oc_c - SW_W'(r_v);
   assign k2     = k_ff - n1;
   assign k3     = k2 - oc_c;
   assign c_left = k_ff < n1;
   assign c_off  = k2 < oc_c;
   assign cbit   = k3 >= SW_W'(ml_v);
   assign off_c  = (p_v - r_v + ml_v) & (p_v - CW'(1));

   // offset level
   assign oc_h    = oc_pow(e_m1);
   assign oc_2h   = oc_h << 1;
   assign o_left  = k_ff < oc_h;
   assign o_right = k_ff < oc_2h;
   assign i_v     = k_ff - oc_2h;
   assign sum1    = {1'b0, off_ff & m_v} + {1'b0, ml_v};
   assign wrap    = (sum1 >= {1'b0, half_v}) ^ (off_ff >= half_v);
   assign bnd     = (off_ff + ml_v) & m_v;
   assign obit    = wrap ^ (i_v >= SW_W'(bnd));

   assign need_c     = ofs_ff && (e_ff == EXP_W'(1));
   assign level_done = ofs_ff ? !o_right : (!c_left && !c_off);
   assign ebit       = ofs_ff ? obit : cbit;

   // two-position switch
   assign m0   = pb_ff[0] ^ pa_ff[0];
   assign m1   = pfx_rdata[0] ^ pb_ff[0];
   assign fbit = (~m0 & m1) ^ off_ff[0];

   assign hit     = (j_ff < nmarks_ff) && (32'(list_rdata) == 32'(i_ff));
   assign acc_n   = acc_ff + CW'(hit);
   assign mask_v  = (CW'(1) << tb_ff) - CW'(1);
   // only set bits of the count contribute a power-of-two block
   assign tot_bit = |(count_ff & (CW'(1) << tb_ff));
   assign tot_add = tot_bit ? (oc_pow(tb_ff) + SW_W'(count_ff & mask_v)) : '0;
   assign tgt_bad = (32'(req_data.target_index) >= 32'(count_ff))
                    || (any_ff && (req_data.target_index <= last_ff));

   always_comb begin
      if (cmd.rd_b) begin
         pfx_raddr = ofs_ff ? (base_ff + half_v) : (base_ff + r_v);
      end else if (cmd.eval) begin
         pfx_raddr = base_ff + CW'(2);
      end else begin
         pfx_raddr = base_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      nmarks_in    = nmarks_ff;
      last_in      = last_ff;
      any_in       = any_ff;
      ready_in     = ready_ff;
      emit_in      = emit_ff;
      total_in     = total_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      j_in         = j_ff;
      tb_in        = tb_ff;
      e_in         = e_ff;
      base_in      = base_ff;
      c_in         = c_ff;
      off_in       = off_ff;
      k_in         = k_ff;
      cc_in        = cc_ff;
      ofs_in       = ofs_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      list_we      = 1'b0;
      pfx_we       = 1'b0;
      pfx_waddr    = i_ff + CW'(1);
      pfx_wdata    = acc_n;
      do_resp      = 1'b0;
      resp_bit     = 1'b0;

      if (cfg_we) begin
         if (cfg_data == '0) begin
            count_in = CW'(1);
         end else if (32'(cfg_data) > 32'(MAX_ITEMS)) begin
            count_in = CW'(MAX_ITEMS);
         end else begin
            count_in = CW'(cfg_data);
         end
         ready_in = 1'b0;
         emit_in  = '0;
      end

      if (cmd.simple) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = ST_OK;
         case (req_data.command)
            CMD_CLEAR: begin
               nmarks_in = '0;
               last_in   = '0;
               any_in    = 1'b0;
               emit_in   = '0;
               ready_in  = 1'b0;
            end
            CMD_MARK: begin
               if (tgt_bad) begin
                  rsp_in.status = ST_BAD;
               end else begin
                  list_we   = 1'b1;
                  nmarks_in = nmarks_ff + CW'(1);
                  last_in   = req_data.target_index;
                  any_in    = 1'b1;
                  ready_in  = 1'b0;
                  emit_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.build_init) begin
         pfx_we    = 1'b1;
         pfx_waddr = '0;
         pfx_wdata = '0;
         i_in      = '0;
         acc_in    = '0;
         j_in      = '0;
         total_in  = '0;
         tb_in     = '0;
         ready_in  = 1'b1;
         emit_in   = '0;
      end

      if (cmd.build_step) begin
         pfx_we = 1'b1;
         acc_in = acc_n;
         i_in   = i_ff + CW'(1);
         if (hit) j_in = j_ff + CW'(1);
      end

      if (cmd.tot_step) begin
         total_in = total_ff + tot_add;
         tb_in    = tb_ff + EXP_W'(1);
      end

      if (cmd.fetch_init) begin
         base_in = '0;
         c_in    = count_ff;
         cc_in   = total_ff;
         k_in    = emit_ff;
         ofs_in  = 1'b0;
      end

      if (cmd.resp_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = ST_EMPTY;
      end

      if (cmd.rd_b) pa_in = pfx_rdata;

      if (cmd.eval) begin
         if (need_c) begin
            pb_in = pfx_rdata;
         end else if (level_done) begin
            do_resp  = 1'b1;
            resp_bit = ebit;
         end else if (ofs_ff) begin
            e_in = e_m1;
            if (o_left) begin
               off_in = off_ff & m_v;
            end else begin
               base_in = base_ff + half_v;
               off_in  = (off_ff + ml_v) & m_v;
               k_in    = k_ff - oc_h;
            end
         end else if (c_left) begin
            c_in  = r_v;
            cc_in = n1;
         end else begin
            ofs_in  = 1'b1;
            base_in = base_ff + r_v;
            e_in    = c_e;
            off_in  = off_c;
            k_in    = k2;
         end
      end

      if (cmd.fin2) begin
         do_resp  = 1'b1;
         resp_bit = fbit;
      end

      if (do_resp) begin
         rsp_valid_in        = 1'b1;
         rsp_in.control_bit  = resp_bit;
         rsp_in.switch_index = emit_ff[SWI_W-1:0];
         rsp_in.last         = (emit_ff + SW_W'(1)) == total_ff;
         rsp_in.status       = ST_OK;
         emit_in             = emit_ff + SW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(RST_CNT);
         nmarks_ff    <= '0;
         last_ff      <= '0;
         any_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         nmarks_ff    <= nmarks_in;
         last_ff      <= last_in;
         any_ff       <= any_in;
         ready_ff     <= ready_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      i_ff     <= i_in;
      acc_ff   <= acc_in;
      j_ff     <= j_in;
      tb_ff    <= tb_in;
      e_ff     <= e_in;
      base_ff  <= base_in;
      c_ff     <= c_in;
      off_ff   <= off_in;
      k_ff     <= k_in;
      cc_ff    <= cc_in;
      ofs_ff   <= ofs_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.ready      = ready_ff;
   assign sts.build_end  = i_ff == count_ff;
   assign sts.hit        = hit;
   assign sts.tot_last   = tb_ff == EXP_W'(CW - 1);
   assign sts.exhausted  = emit_ff >= total_ff;
   assign sts.need_c     = need_c;
   assign sts.level_done = level_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ rtl/cnc_ctrl.sv @@
// ----------------------------------------------------------------------------
// cnc_ctrl: compaction control sequencer
// Accepts requests, runs the prefix build and the per-fetch descent.
// ----------------------------------------------------------------------------
module cnc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          command,
   input  cnc_pkg::dp_sts_type sts,
   output cnc_pkg::dp_cmd_type cmd,
   output logic                busy
);
   import cnc_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_BINIT = 10'b00_0000_0010,
      S_BWAIT = 10'b00_0000_0100,
      S_BSTEP = 10'b00_0000_1000,
      S_TOT   = 10'b00_0001_0000,
      S_FCHK  = 10'b00_0010_0000,
      S_RDA   = 10'b00_0100_0000,
      S_RDB   = 10'b00_1000_0000,
      S_EVAL  = 10'b01_0000_0000,
      S_FIN2  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (command == CMD_FETCH) begin
                  state_in = sts.ready ? S_FCHK : S_BINIT;
               end else begin
                  cmd.simple = 1'b1;
               end
            end
         end
         S_BINIT: begin
            cmd.build_init = 1'b1;
            state_in       = S_BWAIT;
         end
         S_BWAIT: state_in = S_BSTEP;
         S_BSTEP: begin
            if (sts.build_end) begin
               state_in = S_TOT;
            end else begin
               cmd.build_step = 1'b1;
               if (sts.hit) state_in = S_BWAIT;
            end
         end
         S_TOT: begin
            cmd.tot_step = 1'b1;
            if (sts.tot_last) state_in = S_FCHK;
         end
         S_FCHK: begin
            if (sts.exhausted) begin
               cmd.resp_empty = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.fetch_init = 1'b1;
               state_in       = S_RDA;
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            cmd.rd_b = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.need_c) begin
               state_in = S_FIN2;
            end else if (sts.level_done) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_RDA;
            end
         end
         S_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;
endmodule

@@ rtl/compaction_network_control_gen.sv @@
// ----------------------------------------------------------------------------
// compaction_network_control_gen: order-preserving compaction control bits
// Collects kept positions and emits the network's swap controls one per
// fetch request, in forward recursive switch order.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------
//  request  | start, busy, req_data          | taken when start && !busy
//  response | rsp_valid, rsp_data            | one-cycle strobe, no stall
//  csr      | csr_valid, csr_ready, csr_data | write when valid && ready
//
//  Clear, mark and unknown requests answer one cycle after they are taken.
//  The first fetch after reset, a csr write, a clear or a good mark rebuilds
//  the prefix-count memory: a sweep over the item_count positions, then a
//  pass over the count bits to total the switches. Each fetch then walks
//  the recursion levels as read, read and evaluate steps (one extra for the
//  final two-position switch), bounded by the single prefix-memory read port.
//  Reset is synchronous; the mark list and prefix memory need no clearing.
//  The response side cannot stall; busy holds off new requests.
//
module compaction_network_control_gen #(
   parameter int MAX_ITEMS = cnc_pkg::DEF_MAX_ITEMS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  cnc_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output cnc_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [cnc_pkg::CFG_W-1:0] csr_data
);
   import cnc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       cfg_we;

   // csr writes only land while the sequencer is idle
   assign csr_ready = !busy;
   assign cfg_we    = csr_valid && csr_ready;

   cnc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   cnc_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .cfg_we    (cfg_we),
      .cfg_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

@@ rtl/cnc_checker.sv @@
// ----------------------------------------------------------------------------
// cnc_checker: port-level checks
// Response timing and payload rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module cnc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input cnc_pkg::req_type          req_data,
   input logic                      rsp_valid,
   input cnc_pkg::rsp_type          rsp_data,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [cnc_pkg::CFG_W-1:0] csr_data
);
   import cnc_pkg::*;

   // non-fetch requests answer on the next cycle
   a_simple_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command != CMD_FETCH) |=> rsp_valid)
      else $error("missing response to clear/mark request");

   // every response follows a taken request or ongoing work
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("response without request");

   // a response leaves the block ready for the next request
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while responding");

   // error responses carry an empty payload
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK)
      |-> (!rsp_data.control_bit && rsp_data.switch_index == '0 && !rsp_data.last))
      else $error("error response with payload");

   // csr is only accepted while idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy)
      else $error("csr write while busy");
endmodule

bind compaction_network_control_gen cnc_checker u_chk (.*);

@@ bench/compaction_network_control_gen_tb.sv @@
// ----------------------------------------------------------------------------
// compaction_network_control_gen_tb: self-checking bench for the control gen
// Drives clear, mark and fetch requests under several item counts, predicts
// every response from a behavioral copy of the network recursion and checks
// the responses field by field in order.
// ----------------------------------------------------------------------------
module compaction_network_control_gen_tb;
   import cnc_pkg::*;

   localparam int MAX_N      = 1024;
   localparam int STALL_LIMIT = 40000;   // covers the worst-case rebuild sweep

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_data = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_data = '0;

   compaction_network_control_gen u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // behavioral copy of the control generator
   // ---------------------------------------------------------------------
   bit          kept[MAX_N];
   int unsigned prefix[MAX_N + 1];
   int unsigned span;          // item_count
   int unsigned prev_mark;
   bit          have_mark;
   int unsigned next_switch;
   bit          prefix_valid;
   int unsigned switch_total;

   rsp_type     pending_rsp[$];
   int          error_count = 0;
   int          sent_count  = 0;
   bit          idle_on     = 1'b1;
   int          quiet_cycles = 0;

   function automatic int unsigned top_pow2(int unsigned c);
      int unsigned p;
      p = 1;
      while (p <= c / 2) p = p * 2;
      return p;
   endfunction

   function automatic int unsigned offset_switches(int unsigned c);
      if (c <= 1) return 0;
      if (c == 2) return 1;
      return 2 * offset_switches(c / 2) + c / 2;
   endfunction

   function automatic int unsigned compact_switches(int unsigned c);
      int unsigned p;
      if (c == 0) return 0;
      p = top_pow2(c);
      return compact_switches(c - p) + offset_switches(p) + (c - p);
   endfunction

   // swap control of switch k inside an offset network of c positions
   function automatic bit offset_ctrl(int unsigned base, int unsigned c,
                                      int unsigned off, int unsigned k);
      int unsigned half, msk, n, ml, bnd, idx;
      bit m0, m1, wrp;
      if (c == 2) begin
         m0 = (prefix[base + 1] - prefix[base]) & 1;
         m1 = (prefix[base + 2] - prefix[base + 1]) & 1;
         return ((~m0 & m1) ^ off[0]);
      end
      half = c / 2;
      msk  = half - 1;
      n    = offset_switches(half);
      ml   = prefix[base + half] - prefix[base];
      if (k < n) return offset_ctrl(base, half, off & msk, k);
      if (k < 2 * n) return offset_ctrl(base + half, half, (off + ml) & msk, k - n);
      idx = k - 2 * n;
      wrp = (((off & msk) + ml) >= half) ^ (off >= half);
      bnd = (off + ml) & msk;
      return wrp ^ (idx >= bnd);
   endfunction

   // remainder prefix first, then the power-of-two suffix, then the merge column
   function automatic bit compact_ctrl(int unsigned base, int unsigned c, int unsigned k);
      int unsigned p, r, ml, n1, n2;
      p  = top_pow2(c);
      r  = c - p;
      ml = prefix[base + r] - prefix[base];
      n1 = compact_switches(r);
      if (k < n1) return compact_ctrl(base, r, k);
      k  = k - n1;
      n2 = offset_switches(p);
      if (k < n2) return offset_ctrl(base + r, p, (p - r + ml) & (p - 1), k);
      return (k - n2) >= ml;
   endfunction

   function automatic void restart_fetch();
      prefix_valid = 1'b0;
      next_switch  = 0;
   endfunction

   function automatic void reset_model();
      span = MAX_N;
      foreach (kept[i]) kept[i] = 1'b0;
      prev_mark = 0;
      have_mark = 1'b0;
      switch_total = 0;
      restart_fetch();
   endfunction

   function automatic rsp_type expected_response(req_type r);
      rsp_type e;
      e = '0;
      e.status = ST_OK;
      case (r.command)
         CMD_CLEAR: begin
            foreach (kept[i]) kept[i] = 1'b0;
            prev_mark = 0;
            have_mark = 1'b0;
            restart_fetch();
         end
         CMD_MARK: begin
            if (r.target_index >= span || (have_mark && r.target_index <= prev_mark)) begin
               e.status = ST_BAD;
            end else begin
               kept[r.target_index] = 1'b1;
               prev_mark = r.target_index;
               have_mark = 1'b1;
               restart_fetch();
            end
         end
         CMD_FETCH: begin
            if (!prefix_valid) begin
               prefix[0] = 0;
               for (int i = 0; i < span; i++) prefix[i + 1] = prefix[i] + kept[i];
               switch_total = compact_switches(span);
               next_switch  = 0;
               prefix_valid = 1'b1;
            end
            if (next_switch >= switch_total) begin
               e.status = ST_EMPTY;
            end else begin
               e.control_bit  = compact_ctrl(0, span, next_switch);
               e.switch_index = next_switch[SWI_W-1:0];
               e.last         = (next_switch + 1 == switch_total);
               next_switch++;
            end
         end
         default: ;   // unknown request: status ok, nothing changes
      endcase
      return e;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // start is left high after a take; the next call either reloads the
   // request in the same step or drops start for an idle burst
   task automatic send_req(input logic [1:0] cmd, input logic [TGT_W-1:0] tgt);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start                 <= 1'b1;
      req_data.command      <= cmd;
      req_data.target_index <= tgt;
      do @(posedge clock); while (busy);
      pending_rsp.insert(pending_rsp.size(),
                         expected_response('{command: cmd, target_index: tgt}));
      sent_count++;
   endtask

   // stop sending and wait for every pending response, plus fetch slack
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_span(input logic [CFG_W-1:0] v);
      int unsigned c;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      c = v;
      if (c < 1) c = 1;
      if (c > MAX_N) c = MAX_N;
      span = c;
      restart_fetch();
   endtask

   // ---------------------------------------------------------------------
   // response checker
   // ---------------------------------------------------------------------
   task automatic report(input string what, input int got, input int want);
      $display("mismatch @%0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected response, status", rsp_data.status, -1);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.control_bit  !== e.control_bit)
               report("control_bit", rsp_data.control_bit, e.control_bit);
            if (rsp_data.switch_index !== e.switch_index)
               report("switch_index", rsp_data.switch_index, e.switch_index);
            if (rsp_data.last         !== e.last)
               report("last", rsp_data.last, e.last);
            if (rsp_data.status       !== e.status)
               report("status", rsp_data.status, e.status);
         end
      end
   end

   // watchdog: any take, response or csr write counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic fetch_n(input int n);
      for (int i = 0; i < n; i++) send_req(CMD_FETCH, TGT_W'($urandom));
   endtask

   // extremes, every request kind and the named corner cases
   task automatic test_directed();
      send_req(CMD_FETCH, '1);              // first fetch at reset count 1024
      send_req(CMD_MARK, 10'd1023);         // mark after fetching began
      send_req(CMD_MARK, 10'd1023);         // not increasing
      send_req(CMD_FETCH, '0);
      drain();                              // hold off until all answered
      write_span(11'd0);                    // clamps to a single position
      send_req(CMD_FETCH, '0);              // no switches
      send_req(CMD_MARK, 10'd1);            // out of range
      send_req(CMD_MARK, 10'd0);
      send_req(CMD_FETCH, '0);
      write_span(11'd2);
      send_req(CMD_MARK, 10'd1);
      send_req(CMD_MARK, 10'd0);            // below previous mark
      fetch_n(2);                           // the one switch, then exhausted
      send_req(2'd3, '1);                   // unknown request
      send_req(CMD_CLEAR, 10'h2AA);
      send_req(CMD_MARK, 10'd0);
      fetch_n(2);
      write_span(11'd2047);                 // clamps to 1024
      send_req(CMD_MARK, 10'd512);
      send_req(CMD_MARK, 10'd1023);
      fetch_n(3);
   endtask

   // clear, increasing marks with random density, then fetch the network
   task automatic test_random();
      int unsigned c, pos, n, step;
      while (sent_count < 1000) begin
         if ($urandom_range(0, 9) == 0) c = $urandom_range(65, 1024);
         else                           c = $urandom_range(1, 64);
         write_span(CFG_W'(c));
         send_req(CMD_CLEAR, TGT_W'($urandom));
         pos  = $urandom_range(0, 3);
         step = (c / 4 > 1) ? c / 4 : 1;
         while (pos < c && $urandom_range(0, 15) != 0) begin
            send_req(CMD_MARK, TGT_W'(pos));
            if ($urandom_range(0, 7) == 0) send_req(CMD_MARK, TGT_W'($urandom)); // noise
            pos += $urandom_range(1, step);
         end
         if ($urandom_range(0, 9) == 0) send_req(CMD_MARK, TGT_W'($urandom_range(c, 1023)));
         n = compact_switches(c);
         if (n > 60) n = $urandom_range(5, 40);
         else n = n + 1;                    // run into exhaustion
         fetch_n(n);
         if ($urandom_range(0, 4) == 0) begin
            send_req(CMD_MARK, TGT_W'(pos));    // an in-range mark mid-fetch restarts the walk
            fetch_n($urandom_range(1, 6));
         end
         if ($urandom_range(0, 9) == 0) send_req(2'd3, TGT_W'($urandom));
      end
   endtask

   // back-to-back requests, no idle bursts
   task automatic test_streaming();
      idle_on = 1'b0;
      write_span(11'd48);
      send_req(CMD_CLEAR, '0);
      for (int i = 0; i < 48; i += $urandom_range(1, 5)) send_req(CMD_MARK, TGT_W'(i));
      fetch_n(compact_switches(48) + 2);
   endtask

   initial begin
      reset_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_streaming();
      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
